/* hw/rtl/ohs_pkg.sv */
// Shared types and constants for the open-addressing hash set.
`default_nettype none
package ohs_pkg;

  localparam int unsigned TABLE_SLOTS = 8192;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned KEY_W       = 32;

  localparam logic [KEY_W-1:0] HASH_MULT    = 32'h9E37_79B1;
  localparam int unsigned      HASH_PRESHIFT = 3;
  localparam int unsigned      HASH_FOLD     = 13;

  localparam logic [KEY_W-1:0] SLOT_EMPTY = '0;
  localparam logic [KEY_W-1:0] SLOT_TOMB  = KEY_W'(1);

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic success;
    logic key_rejected;
  } rsp_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_KEY_IDX,
    WR_KEY_TOMB,
    WR_TOMB_IDX,
    WR_CLEAR
  } wr_op_e;

  // controller -> datapath
  typedef struct packed {
    logic   load;
    logic   hash;
    logic   rd;
    logic   step;
    wr_op_e wr_op;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       reserved;
    logic [1:0] mode;
    logic       empty;
    logic       tomb;
    logic       match;
    logic       last;
    logic       have_tomb;
    logic       clr_last;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/ohs_datapath.sv */
// Slot memory, hash unit, probe index and tombstone tracking.
`default_nettype none
module ohs_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ohs_pkg::req_t req_i,
  input  wire ohs_pkg::cmd_t cmd_i,
  output ohs_pkg::sts_t      sts_o
);
  import ohs_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  logic [KEY_W-1:0] slot_mem [TABLE_SLOTS];

  logic [KEY_W-1:0]  key_q, rdata_q;
  logic [1:0]        mode_q;
  logic              reserved_q;
  logic [SLOT_W-1:0] idx_q, tomb_q, cnt_q, clr_q;
  logic              have_tomb_q;

  logic [KEY_W-1:0]  hv_pre, hv_fold, hv_prod;
  logic [SLOT_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic              wr_en;

  // hash: shift, fold, multiply; low bits pick the home slot
  always_comb begin
    hv_pre  = key_q >> HASH_PRESHIFT;
    hv_fold = hv_pre ^ (hv_pre >> HASH_FOLD);
    hv_prod = hv_fold * HASH_MULT;
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_q;
    wr_data = key_q;
    case (cmd_i.wr_op)
      WR_KEY_IDX:  wr_addr = idx_q;
      WR_KEY_TOMB: wr_addr = tomb_q;
      WR_TOMB_IDX: wr_data = SLOT_TOMB;
      WR_CLEAR: begin
        wr_addr = clr_q;
        wr_data = SLOT_EMPTY;
      end
      default:     wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= slot_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      have_tomb_q <= 1'b0;
    end else begin
      if (cmd_i.wr_op == WR_CLEAR) begin
        clr_q <= clr_q + SLOT_W'(1);
      end
      if (cmd_i.hash) begin
        have_tomb_q <= 1'b0;
      end else if (cmd_i.step && (rdata_q == SLOT_TOMB) && !have_tomb_q) begin
        have_tomb_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q      <= req_i.key;
      mode_q     <= req_i.mode;
      reserved_q <= (req_i.key[KEY_W-1:1] == '0);
    end
    if (cmd_i.hash) begin
      idx_q <= hv_prod[SLOT_W-1:0];
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + SLOT_W'(1);
      cnt_q <= cnt_q + SLOT_W'(1);
      if ((rdata_q == SLOT_TOMB) && !have_tomb_q) begin
        tomb_q <= idx_q;
      end
    end
  end

  always_comb begin
    sts_o.reserved  = reserved_q;
    sts_o.mode      = mode_q;
    sts_o.empty     = (rdata_q == SLOT_EMPTY);
    sts_o.tomb      = (rdata_q == SLOT_TOMB);
    sts_o.match     = (rdata_q == key_q);
    sts_o.last      = (cnt_q == SLOT_LAST);
    sts_o.have_tomb = have_tomb_q;
    sts_o.clr_last  = (clr_q == SLOT_LAST);
  end

endmodule
`default_nettype wire

/* hw/rtl/ohs_ctrl.sv */
// Sequencer for clearing, hashing and probing the slot table.
`default_nettype none
module ohs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  output ohs_pkg::rsp_t      rsp_o,
  output ohs_pkg::cmd_t      cmd_o,
  input  wire ohs_pkg::sts_t sts_i
);
  import ohs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  rsp_t   rsp_q, rsp_d;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    cmd_o      = '0;
    cmd_o.wr_op = WR_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_op = WR_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        if (sts_i.reserved) begin
          done_d  = 1'b1;
          rsp_d   = '{success: 1'b0, key_rejected: 1'b1};
          state_d = S_IDLE;
        end else begin
          case (sts_i.mode)
            MODE_LOOKUP, MODE_INSERT, MODE_REMOVE: state_d = S_READ;
            default: begin
              done_d  = 1'b1;
              rsp_d   = '{success: 1'b0, key_rejected: 1'b0};
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        done_d  = 1'b1;
        rsp_d   = '{success: 1'b0, key_rejected: 1'b0};
        state_d = S_IDLE;
        case (sts_i.mode)
          MODE_INSERT: begin
            if (sts_i.match) begin
              rsp_d.success = 1'b1;
            end else if (sts_i.empty) begin
              cmd_o.wr_op   = sts_i.have_tomb ? WR_KEY_TOMB : WR_KEY_IDX;
              rsp_d.success = 1'b1;
            end else if (sts_i.last) begin
              // wrapped all the way: fall back to the first tombstone seen
              if (sts_i.have_tomb) begin
                cmd_o.wr_op   = WR_KEY_TOMB;
                rsp_d.success = 1'b1;
              end else if (sts_i.tomb) begin
                cmd_o.wr_op   = WR_KEY_IDX;
                rsp_d.success = 1'b1;
              end
            end else begin
              done_d     = 1'b0;
              cmd_o.step = 1'b1;
              state_d    = S_READ;
            end
          end
          MODE_REMOVE: begin
            if (sts_i.empty) begin
              rsp_d.success = 1'b0;
            end else if (sts_i.match) begin
              cmd_o.wr_op   = WR_TOMB_IDX;
              rsp_d.success = 1'b1;
            end else if (!sts_i.last) begin
              done_d     = 1'b0;
              cmd_o.step = 1'b1;
              state_d    = S_READ;
            end
          end
          default: begin
            if (sts_i.match) begin
              rsp_d.success = 1'b1;
            end else if (!sts_i.empty && !sts_i.last) begin
              done_d     = 1'b0;
              cmd_o.step = 1'b1;
              state_d    = S_READ;
            end
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/open_addressing_hash_set_top.sv */
// Top level of the linear-probing hash set with tombstones.
//
// Holds a set of 32-bit keys in a table of ohs_pkg::TABLE_SLOTS slots
// (8192). After reset the block clears the table one slot per cycle, so
// busy stays high until every slot is cleared; no request is taken before.
// A request beat (mode, key) is taken when start is high and busy is low.
// The home slot is a shift/fold/multiply hash of the key; the probe then
// walks forward through the table, wrapping, one slot at a time (the
// single slot memory is read in S_READ and its registered data checked in
// S_CHECK before the next address is issued), visiting 1..TABLE_SLOTS
// slots. Reserved keys 0 and 1, and mode 3, answer from S_HASH without
// touching the table. The result beat appears on rsp_o with done_o high
// for exactly one cycle; the receiver cannot stall it, and busy is
// already low in that cycle so a new request can be taken alongside it.
// Inserts into a full table with no tombstone report success 0.
`default_nettype none
module open_addressing_hash_set_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ohs_pkg::req_t req_i,
  output logic               done_o,
  output ohs_pkg::rsp_t      rsp_o
);
  import ohs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ohs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  ohs_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
`default_nettype wire

/* hw/rtl/ohs_checker.sv */
// Port-level checks for the hash set top level, with bind.
`default_nettype none
module ohs_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire ohs_pkg::req_t req_i,
  input wire logic          done_o,
  input wire ohs_pkg::rsp_t rsp_o
);
  import ohs_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result beats");

  a_reject_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.key_rejected) |-> !rsp_o.success)
    else $error("rejected key reported success");

  a_reject_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.key[KEY_W-1:1] == '0))
      |-> ##2 (done_o && rsp_o.key_rejected))
    else $error("reserved key not rejected");

endmodule

bind open_addressing_hash_set_top ohs_checker u_ohs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
`default_nettype wire
